// ===== hw/rtl/dcrc16_pkg.sv =====
// Package with shared types, constants and CRC helper functions for the dual CRC-16 checker.
package dcrc16_pkg;

  localparam int DataWidth = 8;
  localparam int CrcWidth  = 16;

  localparam logic [CrcWidth-1:0] CRC_POLY = 16'h8005;
  localparam logic [CrcWidth-1:0] CRC_INIT = 16'h0000;

  // One input byte as it travels from the input register to the CRC core.
  typedef struct packed {
    logic [DataWidth-1:0] data_byte;
    logic                 last_byte;
    logic [CrcWidth-1:0]  reference_crc;
  } in_item_t;

  // Handshake between the input register and the CRC core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_req_t;

  // Bit reversal of one byte.
  function automatic logic [DataWidth-1:0] mirror8(input logic [DataWidth-1:0] v);
    logic [DataWidth-1:0] r;
    for (int i = 0; i < DataWidth; i++) begin
      r[i] = v[DataWidth-1-i];
    end
    return r;
  endfunction

  // Bit reversal of a full CRC word.
  function automatic logic [CrcWidth-1:0] mirror16(input logic [CrcWidth-1:0] v);
    logic [CrcWidth-1:0] r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[i] = v[CrcWidth-1-i];
    end
    return r;
  endfunction

  // Shifts one byte MSB-first into a CRC register; eight XOR steps unroll into combinational logic.
  function automatic logic [CrcWidth-1:0] crc_feed(input logic [CrcWidth-1:0]  crc,
                                                   input logic [DataWidth-1:0] data);
    logic [CrcWidth-1:0] c;
    logic                fb;
    c = crc;
    for (int k = DataWidth - 1; k >= 0; k--) begin
      fb = c[CrcWidth-1] ^ data[k];
      c  = {c[CrcWidth-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dcrc16_in_if.sv =====
// Interface for the input byte channel of the dual CRC-16 checker.
interface dcrc16_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] reference_crc;

  modport source (output valid, output data_byte, output last_byte, output reference_crc,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input reference_crc,
                output ready);
endinterface

// ===== hw/rtl/dcrc16_out_if.sv =====
// Interface for the result channel of the dual CRC-16 checker.
interface dcrc16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_plain;
  logic [15:0] crc_reflected;
  logic        ref_match;

  modport source (output valid, output crc_plain, output crc_reflected, output ref_match,
                  input ready);
  modport sink (input valid, input crc_plain, input crc_reflected, input ref_match,
                output ready);
endinterface

// ===== hw/rtl/dcrc16_in_stage.sv =====
// Input register that captures one byte transaction and hands it to the CRC core.
module dcrc16_in_stage (
  input  logic                  clk,
  input  logic                  rst,
  dcrc16_in_if.sink             bytes,
  output dcrc16_pkg::stage_req_t req,
  input  logic                  req_ready
);
  import dcrc16_pkg::*;

  logic     valid;
  in_item_t item;

  // The register takes a new transaction when empty or when its content moves on.
  assign bytes.ready = !valid || req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (bytes.ready) begin
      valid <= bytes.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      item.data_byte     <= bytes.data_byte;
      item.last_byte     <= bytes.last_byte;
      item.reference_crc <= bytes.reference_crc;
    end
  end

  assign req.valid = valid;
  assign req.item  = item;

endmodule

// ===== hw/rtl/dcrc16_core.sv =====
// CRC core: running plain and reflected CRC registers plus the result register.
module dcrc16_core (
  input  logic                  clk,
  input  logic                  rst,
  input  dcrc16_pkg::stage_req_t req,
  output logic                  req_ready,
  dcrc16_out_if.source          result
);
  import dcrc16_pkg::*;

  logic [CrcWidth-1:0] running_plain;
  logic [CrcWidth-1:0] running_reflected;
  logic [CrcWidth-1:0] running_plain_next;
  logic [CrcWidth-1:0] running_reflected_next;
  logic [CrcWidth-1:0] final_reflected;
  logic                match_next;
  logic                res_valid;
  logic [CrcWidth-1:0] res_plain;
  logic [CrcWidth-1:0] res_reflected;
  logic                res_match;
  logic                fire;

  // A byte that ends a region needs a free result slot; other bytes always proceed.
  assign req_ready = !req.item.last_byte || !res_valid || result.ready;
  assign fire      = req.valid && req_ready;

  // Byte-wide CRC updates and the final comparison.
  always_comb begin
    running_plain_next     = crc_feed(running_plain, req.item.data_byte);
    running_reflected_next = crc_feed(running_reflected, mirror8(req.item.data_byte));
    final_reflected        = mirror16(running_reflected_next);
    match_next             = (running_plain_next == req.item.reference_crc) ||
                             (final_reflected == req.item.reference_crc);
  end

  // Running CRCs restart from zero after the last byte of a region.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_plain     <= CRC_INIT;
      running_reflected <= CRC_INIT;
    end else if (fire) begin
      if (req.item.last_byte) begin
        running_plain     <= CRC_INIT;
        running_reflected <= CRC_INIT;
      end else begin
        running_plain     <= running_plain_next;
        running_reflected <= running_reflected_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && req.item.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire && req.item.last_byte) begin
      res_plain     <= running_plain_next;
      res_reflected <= final_reflected;
      res_match     <= match_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.crc_plain     = res_plain;
  assign result.crc_reflected = res_reflected;
  assign result.ref_match     = res_match;

endmodule

// ===== hw/rtl/dual_crc16_region_checker_unit.sv =====
// A result can be taken once the transaction that carries the last byte has passed the input
// register and then the result register.
// Throughput: one byte per cycle unless a byte that ends a region is held back; the byte-wide CRC update is XOR logic.
// A byte that ends a region waits only while the result register still holds an untaken result.
// Reset (synchronous, active high) empties the input and result registers and
// clears both running CRCs to zero.
module dual_crc16_region_checker_unit (
  input  logic          clk,
  input  logic          rst,
  dcrc16_in_if.sink     bytes,
  dcrc16_out_if.source  result
);
  import dcrc16_pkg::*;

  stage_req_t req;
  logic       req_ready;

  dcrc16_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .req       (req),
    .req_ready (req_ready)
  );

  dcrc16_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .result    (result)
  );

endmodule
